// ===== hdl/gsp_pkg.sv =====
`timescale 1ns / 1ps

package gsp_pkg;

    // Fixed fractional width of the playback phase and of rate_step (rate_step is Q8.16).
    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 16;
    localparam int WADDR_W   = 12;
    localparam int RATE_W    = 24;
    localparam int LEN_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [RATE_W-1:0] RATE_STEP_RESET = RATE_W'(65536);
    localparam logic [LEN_W-1:0]  SAMPLE_LENGTH_RESET = '0;
    localparam logic              LOOP_ENABLE_RESET = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_STEP     = 2'd0,
        CFG_SAMPLE_LENGTH = 2'd1,
        CFG_LOOP_ENABLE   = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_GATE  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } item_mode_t;

    typedef enum logic [1:0] {
        VOICE_IDLE   = 2'd0,
        VOICE_ATTACK = 2'd1,
        VOICE_DECAY  = 2'd2
    } voice_state_t;

    typedef struct packed {
        item_mode_t                  mode;
        logic [WADDR_W-1:0]          write_address;
        logic signed [SAMPLE_W-1:0]  sample_value;
        logic                        gate_on;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  audio_out;
        voice_state_t                voice_state;
    } out_item_t;

    // Per-tick information handed from the voice control to the output stage.
    typedef struct packed {
        logic          valid;
        logic          in_range;
        voice_state_t  voice_state;
    } tick_info_t;

endpackage

// ===== hdl/gsp_sample_mem.sv =====
`timescale 1ns / 1ps

module gsp_sample_mem #(
    parameter int DEPTH = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic signed [gsp_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic signed [gsp_pkg::SAMPLE_W-1:0] rd_data
);
    import gsp_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    // The read register only changes on a read, so it holds while the
    // result stage downstream is stalled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/gsp_voice.sv =====
`timescale 1ns / 1ps

module gsp_voice #(
    parameter int DEPTH = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  gsp_pkg::in_item_t                  item,
    input  logic                               cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               mem_wr_en,
    output logic [ADDR_W-1:0]                  mem_wr_addr,
    output logic                               mem_rd_en,
    output logic [ADDR_W-1:0]                  mem_rd_addr,
    output gsp_pkg::tick_info_t                tick
);
    import gsp_pkg::*;

    localparam int IDX_W   = ADDR_W + 1;
    localparam int PHASE_W = IDX_W + FRAC_BITS;
    localparam int SUM_W   = ((PHASE_W > RATE_W) ? PHASE_W : RATE_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(DEPTH) << FRAC_BITS;

    logic [RATE_W-1:0]  rate_reg;
    logic [LEN_W-1:0]   length_reg;
    logic               loop_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    voice_state_t       state_reg;
    voice_state_t       state_next;

    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   len_clamp;
    logic               in_range;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   sum_sat;
    logic [SUM_W-1:0]   end_pos;
    logic               hit_end;
    logic               is_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_STEP_RESET;
            length_reg <= SAMPLE_LENGTH_RESET;
            loop_reg   <= LOOP_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RATE_STEP:     rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_SAMPLE_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                CFG_LOOP_ENABLE:   loop_reg   <= cfg_data[0];
                CFG_UNUSED:        ;
            endcase
        end
    end

    // Phase datapath: read index, range check and the saturating advance.
    always_comb
    begin
        idx       = phase_reg[PHASE_W-1:FRAC_BITS];
        len_clamp = (32'(length_reg) > 32'(DEPTH)) ? IDX_W'(DEPTH) : IDX_W'(length_reg);
        in_range  = (state_reg == VOICE_ATTACK) && (idx < len_clamp);
        sum       = SUM_W'(phase_reg) + SUM_W'(rate_reg);
        sum_sat   = (sum > LIMIT) ? LIMIT : sum;
        end_pos   = SUM_W'(len_clamp) << FRAC_BITS;
        hit_end   = (sum_sat >= end_pos);
        is_tick   = accept && (item.mode == MODE_TICK);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            unique case (item.mode)
                MODE_GATE:
                begin
                    if (item.gate_on)
                        state_next = VOICE_ATTACK;
                    else if (state_reg != VOICE_IDLE)
                        state_next = VOICE_DECAY;
                end
                MODE_TICK:
                begin
                    unique case (state_reg)
                        VOICE_ATTACK:
                            if (hit_end && !loop_reg)
                                state_next = VOICE_DECAY;
                        VOICE_DECAY:
                            state_next = VOICE_IDLE;
                        default:
                            state_next = state_reg;
                    endcase
                end
                MODE_WRITE, MODE_NONE: ;
            endcase
        end
    end

    // Outputs of the state machine: phase update, memory access, tick info.
    always_comb
    begin
        phase_next = phase_reg;
        if (is_tick)
        begin
            unique case (state_reg)
                VOICE_ATTACK:
                    phase_next = (hit_end && loop_reg) ? '0 : PHASE_W'(sum_sat);
                VOICE_DECAY:
                    phase_next = '0;
                default:
                    phase_next = phase_reg;
            endcase
        end

        mem_wr_en   = accept && (item.mode == MODE_WRITE)
                      && (32'(item.write_address) < 32'(DEPTH));
        mem_wr_addr = ADDR_W'(item.write_address);
        mem_rd_en   = is_tick && in_range;
        mem_rd_addr = idx[ADDR_W-1:0];

        tick.valid       = is_tick;
        tick.in_range    = in_range;
        tick.voice_state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= VOICE_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && state_reg == VOICE_DECAY) |=> (state_reg == VOICE_IDLE && phase_reg == '0))
        else $error("decay tick did not return the voice to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg <= PHASE_W'(LIMIT)))
        else $error("phase exceeded its saturation limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (32'(idx) < 32'(DEPTH)))
        else $error("sample read outside memory");

endmodule

// ===== hdl/gsp_out_stage.sv =====
`timescale 1ns / 1ps

module gsp_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gsp_pkg::tick_info_t                 tick,
    input  logic signed [gsp_pkg::SAMPLE_W-1:0] rd_data,
    output logic                                in_hold,
    output logic                                result_valid,
    input  logic                                result_stall,
    output gsp_pkg::out_item_t                  result
);
    import gsp_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_in_range_reg;
    voice_state_t  s1_state_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_reg;
    logic          s1_adv;

    // The read stage moves on whenever the result register is free or being taken.
    always_comb
    begin
        s1_adv         = s1_valid_reg && (!out_valid_reg || !result_stall);
        in_hold        = s1_valid_reg && !s1_adv;
        s1_valid_next  = tick.valid || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid)
        begin
            s1_in_range_reg <= tick.in_range;
            s1_state_reg    <= tick.voice_state;
        end
        if (s1_adv)
        begin
            out_reg.audio_out   <= s1_in_range_reg ? rd_data : '0;
            out_reg.voice_state <= s1_state_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_hold |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("input held without a full result path");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_hold |=> (s1_valid_reg && $stable(s1_state_reg) && $stable(s1_in_range_reg)))
        else $error("held read stage lost its contents");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> result_valid)
        else $error("advanced tick did not reach the result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid |-> !in_hold)
        else $error("tick entered a held read stage");

endmodule

// ===== hdl/gated_sample_player.sv =====
`timescale 1ns / 1ps

// Gated one-voice sample player. Each transaction on the item channel is a
// sample write, a gate event or an output tick; only a tick yields a result
// transaction, which passes through the synchronous sample memory read stage
// and then the result register. The block takes one item per cycle; it stalls
// the item channel only when both the memory read stage and the result
// register are full and the result channel is stalled. The sample memory is
// not cleared after reset, so an entry must be written before playback reads
// it. Configuration writes take effect at the next clock edge and are meant to
// be issued while no tick is in flight.
module gated_sample_player #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  gsp_pkg::in_item_t                  item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output gsp_pkg::out_item_t                 result,
    input  logic                               cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gsp_pkg::*;

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    logic                       accept;
    logic                       mem_wr_en;
    logic [ADDR_W-1:0]          mem_wr_addr;
    logic                       mem_rd_en;
    logic [ADDR_W-1:0]          mem_rd_addr;
    logic signed [SAMPLE_W-1:0] mem_rd_data;
    tick_info_t                 tick;
    logic                       in_hold;

    assign accept     = item_valid && !in_hold;
    assign item_stall = in_hold;

    gsp_voice #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_voice (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .tick        (tick)
    );

    gsp_sample_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (item.sample_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gsp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .rd_data      (mem_rd_data),
        .in_hold      (in_hold),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== tb/gsp_player_checker.sv =====
`timescale 1ns / 1ps

module gsp_player_checker #(
    parameter int MEM_DEPTH = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic                               item_stall,
    input  gsp_pkg::in_item_t                  item,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  gsp_pkg::out_item_t                 result,
    input  logic                               cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatch_count,
    output int                                 samples_due
);
    import gsp_pkg::*;

    // One guard bit above the integer part, plus room for the add before clamping.
    localparam int PHASE_W = 30;
    localparam logic [PHASE_W-1:0] PHASE_LIMIT = PHASE_W'(MEM_DEPTH) << FRAC_BITS;

    logic signed [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
    logic [PHASE_W-1:0]         play_phase;
    voice_state_t               voice;
    logic [RATE_W-1:0]          rate_step;
    logic [LEN_W-1:0]           sample_length;
    logic                       loop_enable;
    out_item_t                  expected_samples [$];
    out_item_t                  oldest;

    initial
    begin
        for (int i = 0; i < MEM_DEPTH; i++)
        begin
            sample_mem[i] = '0;
        end
    end

    task automatic play_item(input in_item_t it);
        logic [LEN_W-1:0]             play_len;
        logic [PHASE_W-1:0]           end_phase;
        logic [PHASE_W-1:0]           next_phase;
        logic [PHASE_W-FRAC_BITS-1:0] read_idx;
        out_item_t                    want;
        want = '0;
        case (it.mode)
            MODE_WRITE:
            begin
                if (it.write_address < MEM_DEPTH)
                    sample_mem[it.write_address] = it.sample_value;
            end
            MODE_GATE:
            begin
                if (it.gate_on)
                    voice = VOICE_ATTACK;
                else if (voice != VOICE_IDLE)
                    voice = VOICE_DECAY;
            end
            MODE_TICK:
            begin
                play_len = (sample_length > LEN_W'(MEM_DEPTH)) ? LEN_W'(MEM_DEPTH)
                                                               : sample_length;
                end_phase = PHASE_W'(play_len) << FRAC_BITS;
                if (voice == VOICE_ATTACK)
                begin
                    read_idx = play_phase[PHASE_W-1:FRAC_BITS];
                    if (read_idx < play_len)
                        want.audio_out = sample_mem[read_idx];
                    next_phase = play_phase + PHASE_W'(rate_step);
                    if (next_phase > PHASE_LIMIT)
                        next_phase = PHASE_LIMIT;
                    play_phase = next_phase;
                    if (play_phase >= end_phase)
                    begin
                        if (loop_enable)
                            play_phase = '0;
                        else
                            voice = VOICE_DECAY;
                    end
                end
                else if (voice == VOICE_DECAY)
                begin
                    play_phase = '0;
                    voice = VOICE_IDLE;
                end
                want.voice_state = voice;
                expected_samples.push_back(want);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_samples.delete();
            play_phase = '0;
            voice = VOICE_IDLE;
            rate_step = RATE_STEP_RESET;
            sample_length = SAMPLE_LENGTH_RESET;
            loop_enable = LOOP_ENABLE_RESET;
            mismatch_count = 0;
            samples_due <= 0;
        end
        else
        begin
            // Results are matched before new ticks are queued, so a result can
            // never pair with a tick accepted at the same edge.
            if (result_valid && !result_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: audio_out %0d, voice_state %0d",
                             $time, $signed(result.audio_out), result.voice_state);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_samples.pop_front();
                    if (result.audio_out !== oldest.audio_out)
                    begin
                        $display("%0t: audio_out expected %0d, actual %0d", $time,
                                 $signed(oldest.audio_out), $signed(result.audio_out));
                        mismatch_count++;
                    end
                    if (result.voice_state !== oldest.voice_state)
                    begin
                        $display("%0t: voice_state expected %0d, actual %0d", $time,
                                 oldest.voice_state, result.voice_state);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RATE_STEP:     rate_step = cfg_data[RATE_W-1:0];
                    CFG_SAMPLE_LENGTH: sample_length = cfg_data[LEN_W-1:0];
                    CFG_LOOP_ENABLE:   loop_enable = cfg_data[0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                play_item(item);
            samples_due <= expected_samples.size();
        end
    end

endmodule

// ===== tb/gated_sample_player_test.sv =====
`timescale 1ns / 1ps

module gated_sample_player_test;
    import gsp_pkg::*;

    localparam int MEM_DEPTH = 4096;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    in_item_t              item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_item_t             result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatch_count;
    int samples_due;

    // Entries below loaded_prefix are all written, so lengths up to it are safe.
    bit written [MEM_DEPTH];
    int loaded_prefix = 0;
    bit quiet = 1'b0;
    bit gappy = 1'b1;
    int hold_requests = 0;
    int holds_done = 0;

    gated_sample_player #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    gsp_player_checker #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .samples_due(samples_due)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #16_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Output side back-pressure: random bursts, or one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                result_stall <= 1'b1;
                repeat (60) @(posedge clk);
                holds_done++;
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic in_item_t random_item(input item_mode_t mode);
        in_item_t it;
        it.mode = mode;
        it.write_address = WADDR_W'($urandom);
        it.sample_value = SAMPLE_W'($urandom);
        it.gate_on = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t gate_item(input bit on);
        in_item_t it;
        it = random_item(MODE_GATE);
        it.gate_on = on;
        return it;
    endfunction

    function automatic in_item_t write_item(input int addr, input logic [SAMPLE_W-1:0] value);
        in_item_t it;
        it = random_item(MODE_WRITE);
        it.write_address = WADDR_W'(addr);
        it.sample_value = value;
        return it;
    endfunction

    // Called right after a rising edge; returns in the step of acceptance.
    task automatic send_item(input in_item_t it);
        if (gappy && !quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        if (it.mode == MODE_WRITE)
        begin
            written[it.write_address] = 1'b1;
            while (loaded_prefix < MEM_DEPTH && written[loaded_prefix])
                loaded_prefix++;
        end
    endtask

    // Stops offering and waits until every tick has produced its result.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (samples_due != 0)
            @(posedge clk);
        // Writes and gate events still in flight leave no trace in the count.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_playback(input logic [RATE_W-1:0] rate, input logic [LEN_W-1:0] len,
                                input bit loop_on);
        logic [CFG_DATA_W-1:0] d;
        write_reg(CFG_RATE_STEP, rate);
        // Bits above the register width are junk that the block must drop.
        d = CFG_DATA_W'($urandom);
        d[LEN_W-1:0] = len;
        write_reg(CFG_SAMPLE_LENGTH, d);
        d = CFG_DATA_W'($urandom);
        d[0] = loop_on;
        write_reg(CFG_LOOP_ENABLE, d);
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] edge_values [8];
        logic [RATE_W-1:0]   rate;
        logic [LEN_W-1:0]    len;
        bit                  loop_on;
        int                  pick;
        int                  addr;

        edge_values = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                        16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length after reset: the attack tick is silent and decays at once.
        send_item(gate_item(1'b1));
        send_item(random_item(MODE_TICK));
        send_item(random_item(MODE_TICK));
        send_item(random_item(MODE_TICK));
        send_item(gate_item(1'b0));
        send_item(random_item(MODE_NONE));

        for (int i = 0; i < 8; i++)
        begin
            send_item(write_item(i, edge_values[i]));
        end
        send_item(write_item(MEM_DEPTH - 1, 16'h1234));
        drain_results();
        set_playback(24'd65536, 13'd8, 1'b0);
        send_item(gate_item(1'b1));
        repeat (3) send_item(random_item(MODE_TICK));
        send_item(gate_item(1'b0));
        send_item(random_item(MODE_TICK));
        send_item(random_item(MODE_TICK));

        for (int phase_no = 0; phase_no < 14; phase_no++)
        begin
            drain_results();
            quiet = (phase_no >= 12);
            gappy = ($urandom_range(0, 2) != 0);

            if (phase_no == 5)
            begin
                for (int a = 0; a < MEM_DEPTH; a++)
                begin
                    if (!written[a])
                        send_item(write_item(a, SAMPLE_W'($urandom)));
                end
                drain_results();
            end

            pick = $urandom_range(0, 5);
            case (pick)
                0: rate = '0;
                1: rate = '1;
                2: rate = 24'd65536;
                3: rate = RATE_W'($urandom);
                default: rate = RATE_W'($urandom_range(1, 24'h3FFFF));
            endcase
            if (loaded_prefix < MEM_DEPTH)
                len = LEN_W'($urandom_range(0, loaded_prefix));
            else
            begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: len = 13'd4096;
                    1: len = '1;
                    2: len = LEN_W'($urandom);
                    default: len = LEN_W'($urandom_range(1, 64));
                endcase
            end
            loop_on = 1'($urandom);
            case (phase_no)
                1:
                begin
                    rate = '0;
                    loop_on = 1'b1;
                end
                6:
                begin
                    rate = '1;
                    len = 13'd4096;
                    loop_on = 1'b0;
                end
                7:
                begin
                    rate = '1;
                    len = '1;
                    loop_on = 1'b1;
                end
                8:
                begin
                    len = '0;
                    loop_on = 1'b1;
                end
                default: ;
            endcase
            set_playback(rate, len, loop_on);

            if (phase_no == 3)
            begin
                // The output side holds off while ticks keep coming, so the
                // pipeline fills and the input stalls.
                gappy = 1'b0;
                hold_requests++;
                send_item(gate_item(1'b1));
                repeat (20) send_item(random_item(MODE_TICK));
            end

            for (int n = 0; n < 30; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    send_item(random_item(MODE_TICK));
                else if (pick < 65)
                begin
                    if (loaded_prefix < MEM_DEPTH && $urandom_range(0, 1) == 0)
                        addr = loaded_prefix;
                    else
                        addr = $urandom_range(0, MEM_DEPTH - 1);
                    send_item(write_item(addr, SAMPLE_W'($urandom)));
                end
                else if (pick < 75)
                    send_item(gate_item(1'b1));
                else if (pick < 85)
                    send_item(gate_item(1'b0));
                else if (pick < 90)
                    send_item(random_item(MODE_NONE));
                else if (pick < 93)
                    drain_results();
                else
                    send_item(random_item(MODE_TICK));
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
